FILE: hdl/segment_plane_intersection_assert.svh
// assertion macros shared by the segment/plane checker
`ifndef SEGMENT_PLANE_INTERSECTION_ASSERT_SVH
`define SEGMENT_PLANE_INTERSECTION_ASSERT_SVH

// condition that holds whenever reset is low
`define SPI_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// same-cycle implication
`define SPI_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SPI_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/spi_pkg.sv
// shared types and constants of the segment/plane intersection block
package spi_pkg;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_DISJOINT = 2'd0,
      STATUS_POINT    = 2'd1,
      STATUS_IN_PLANE = 2'd2
   } status_type;

   // width of the parallel threshold register and its reset value
   localparam int EPS_WIDTH = 31;
   localparam logic [EPS_WIDTH-1:0] EPS_RESET = 31'd1;

   // fraction bits of the segment parameter t
   localparam int TQ_FRAC = 32;

endpackage

FILE: hdl/segment_plane_intersection.sv
// segment_plane_intersection: pipelined line segment / plane intersection
//
// usage
//   req_ channel: one transaction carries the segment endpoints, a point on
//   the plane and the plane normal, all signed fixed point. a transaction is
//   taken at a rising edge with req_valid high and req_stall low.
//   rsp_ channel: one transaction per request, in order, with hit_status
//   (0 disjoint, 1 point, 2 segment in plane) and the hit point (zero unless
//   the status is a point). taken when rsp_valid is high and rsp_stall low.
//   csr_ channel: writes the parallel threshold; csr_ready is always high.
//   write it only while no transaction is in flight.
// pipeline
//   a transaction passes through these registered stages in order: operand
//   differences, six products, two dot sums, classification, a 33-stage
//   restoring divider (one quotient bit per stage), the t*u products and the
//   output register. throughput is one transaction per cycle while rsp_stall is low.
// reset
//   synchronous reset empties the pipeline and sets the threshold to 1.
// back pressure
//   each stage holds while the stage after it is full and stalled, so empty
//   stages keep filling while rsp_stall is high; req_stall rises only once
//   the whole pipeline is full.
module segment_plane_intersection #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [COORD_WIDTH-1:0]       req_start_x,
   input  logic signed [COORD_WIDTH-1:0]       req_start_y,
   input  logic signed [COORD_WIDTH-1:0]       req_start_z,
   input  logic signed [COORD_WIDTH-1:0]       req_end_x,
   input  logic signed [COORD_WIDTH-1:0]       req_end_y,
   input  logic signed [COORD_WIDTH-1:0]       req_end_z,
   input  logic signed [COORD_WIDTH-1:0]       req_plane_pt_x,
   input  logic signed [COORD_WIDTH-1:0]       req_plane_pt_y,
   input  logic signed [COORD_WIDTH-1:0]       req_plane_pt_z,
   input  logic signed [COORD_WIDTH-1:0]       req_normal_x,
   input  logic signed [COORD_WIDTH-1:0]       req_normal_y,
   input  logic signed [COORD_WIDTH-1:0]       req_normal_z,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_hit_status,
   output logic signed [COORD_WIDTH-1:0]       rsp_hit_x,
   output logic signed [COORD_WIDTH-1:0]       rsp_hit_y,
   output logic signed [COORD_WIDTH-1:0]       rsp_hit_z,
   // threshold register write
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [spi_pkg::EPS_WIDTH-1:0]       csr_parallel_epsilon
);

   localparam int CW  = COORD_WIDTH;
   localparam int UW  = CW + 1;              // coordinate differences
   localparam int PW  = 2 * CW + 1;          // one product
   localparam int DW  = PW + 2;              // dot product sum
   localparam int RW  = DW + 1;              // divider remainder
   localparam int QW  = spi_pkg::TQ_FRAC + 1; // quotient, t in [0,1]
   localparam int MW  = QW + 1 + UW;         // t*u product
   localparam int DS  = QW;                  // divider stages
   localparam int ST_SUB  = 0;
   localparam int ST_MUL  = 1;
   localparam int ST_SUM  = 2;
   localparam int ST_CLS  = 3;
   localparam int ST_DIV  = 4;
   localparam int ST_TMUL = ST_DIV + DS;
   localparam int ST_OUT  = ST_TMUL + 1;
   localparam int NS      = ST_OUT + 1;

   // ---------------------------------------------------------------------
   // threshold register
   // ---------------------------------------------------------------------
   logic [spi_pkg::EPS_WIDTH-1:0] eps_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= spi_pkg::EPS_RESET;
      end else if (csr_valid && csr_ready) begin
         eps_ff <= csr_parallel_epsilon;
      end
   end

   // ---------------------------------------------------------------------
   // stage valid bits and load enables
   // a stage loads when it is empty or the stage after it moves on
   // ---------------------------------------------------------------------
   logic [NS-1:0] vld_ff;
   logic [NS-1:0] en;

   assign en[NS-1] = !vld_ff[NS-1] || !rsp_stall;

   for (genvar s = 0; s < NS - 1; s++) begin : g_en
      assign en[s] = !vld_ff[s] || en[s+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int s = 0; s < NS; s++) begin
            if (en[s]) begin
               vld_ff[s] <= (s == 0) ? req_valid : vld_ff[s-1 < 0 ? 0 : s-1];
            end
         end
      end
   end

   assign req_stall = !en[ST_SUB];

   // ---------------------------------------------------------------------
   // stage 0: u = p2 - p1, w = p1 - q
   // ---------------------------------------------------------------------
   logic signed [CW-1:0] in_p1 [3];
   logic signed [CW-1:0] in_p2 [3];
   logic signed [CW-1:0] in_q  [3];
   logic signed [CW-1:0] in_n  [3];

   assign in_p1 = '{req_start_x, req_start_y, req_start_z};
   assign in_p2 = '{req_end_x, req_end_y, req_end_z};
   assign in_q  = '{req_plane_pt_x, req_plane_pt_y, req_plane_pt_z};
   assign in_n  = '{req_normal_x, req_normal_y, req_normal_z};

   logic signed [CW-1:0] sub_p1_ff [3];
   logic signed [CW-1:0] sub_n_ff  [3];
   logic signed [UW-1:0] sub_u_ff  [3];
   logic signed [UW-1:0] sub_w_ff  [3];

   always_ff @(posedge clock) begin
      if (en[ST_SUB]) begin
         for (int i = 0; i < 3; i++) begin
            sub_p1_ff[i] <= in_p1[i];
            sub_n_ff[i]  <= in_n[i];
            sub_u_ff[i]  <= UW'(in_p2[i]) - UW'(in_p1[i]);
            sub_w_ff[i]  <= UW'(in_p1[i]) - UW'(in_q[i]);
         end
      end
   end

   // ---------------------------------------------------------------------
   // stage 1: the six products n*u and n*w
   // ---------------------------------------------------------------------
   logic signed [CW-1:0] mul_p1_ff [3];
   logic signed [UW-1:0] mul_u_ff  [3];
   logic signed [PW-1:0] mul_nu_ff [3];
   logic signed [PW-1:0] mul_nw_ff [3];

   always_ff @(posedge clock) begin
      if (en[ST_MUL]) begin
         for (int i = 0; i < 3; i++) begin
            mul_p1_ff[i] <= sub_p1_ff[i];
            mul_u_ff[i]  <= sub_u_ff[i];
            mul_nu_ff[i] <= PW'(sub_n_ff[i]) * PW'(sub_u_ff[i]);
            mul_nw_ff[i] <= PW'(sub_n_ff[i]) * PW'(sub_w_ff[i]);
         end
      end
   end

   // ---------------------------------------------------------------------
   // stage 2: D = n.u and N = -(n.w)
   // ---------------------------------------------------------------------
   logic signed [CW-1:0] sum_p1_ff [3];
   logic signed [UW-1:0] sum_u_ff  [3];
   logic signed [DW-1:0] sum_d_ff;
   logic signed [DW-1:0] sum_n_ff;

   always_ff @(posedge clock) begin
      if (en[ST_SUM]) begin
         sum_p1_ff <= mul_p1_ff;
         sum_u_ff  <= mul_u_ff;
         sum_d_ff  <= DW'(mul_nu_ff[0]) + DW'(mul_nu_ff[1]) + DW'(mul_nu_ff[2]);
         sum_n_ff  <= -(DW'(mul_nw_ff[0]) + DW'(mul_nw_ff[1]) + DW'(mul_nw_ff[2]));
      end
   end

   // ---------------------------------------------------------------------
   // stage 3: magnitudes, parallel test, range test on t
   // ---------------------------------------------------------------------
   logic [DW-1:0]        cls_ad;
   logic [DW-1:0]        cls_an;
   logic [DW-1:0]        cls_dt;
   logic                 cls_parallel;
   spi_pkg::status_type  cls_status;

   always_comb begin
      cls_ad       = sum_d_ff[DW-1] ? DW'(-sum_d_ff) : DW'(sum_d_ff);
      cls_an       = sum_n_ff[DW-1] ? DW'(-sum_n_ff) : DW'(sum_n_ff);
      cls_dt       = cls_ad >> FRAC_BITS;
      // zero denominator always counts as parallel
      cls_parallel = (sum_d_ff == '0) || (cls_dt < DW'(eps_ff));
      if (cls_parallel) begin
         cls_status = (sum_n_ff == '0) ? spi_pkg::STATUS_IN_PLANE
                                       : spi_pkg::STATUS_DISJOINT;
      end else if ((sum_n_ff != '0) && (sum_n_ff[DW-1] != sum_d_ff[DW-1])) begin
         cls_status = spi_pkg::STATUS_DISJOINT;   // t below zero
      end else if (cls_ad < cls_an) begin
         cls_status = spi_pkg::STATUS_DISJOINT;   // t above one
      end else begin
         cls_status = spi_pkg::STATUS_POINT;
      end
   end

   logic signed [CW-1:0] cls_p1_ff [3];
   logic signed [UW-1:0] cls_u_ff  [3];
   logic [DW-1:0]        cls_ad_ff;
   logic [RW-1:0]        cls_r_ff;
   spi_pkg::status_type  cls_status_ff;

   always_ff @(posedge clock) begin
      if (en[ST_CLS]) begin
         cls_p1_ff     <= sum_p1_ff;
         cls_u_ff      <= sum_u_ff;
         cls_ad_ff     <= cls_ad;
         cls_r_ff      <= RW'(cls_an);
         cls_status_ff <= cls_status;
      end
   end

   // ---------------------------------------------------------------------
   // restoring divider: tq = floor(|N| * 2^32 / |D|), one bit per stage
   // items that are not a hit pass through with don't-care quotient
   // ---------------------------------------------------------------------
   logic signed [CW-1:0] dv_p1_ff     [DS][3];
   logic signed [UW-1:0] dv_u_ff      [DS][3];
   logic [DW-1:0]        dv_ad_ff     [DS];
   logic [RW-1:0]        dv_r_ff      [DS];
   logic [QW-1:0]        dv_q_ff      [DS];
   spi_pkg::status_type  dv_status_ff [DS];

   for (genvar k = 0; k < DS; k++) begin : g_div
      logic signed [CW-1:0] p1_prev [3];
      logic signed [UW-1:0] u_prev  [3];
      logic [DW-1:0]        ad_prev;
      logic [RW-1:0]        r_prev;
      logic [QW-1:0]        q_prev;
      spi_pkg::status_type  status_prev;
      logic [RW-1:0]        cand;
      logic                 ge;

      if (k == 0) begin : g_first
         assign p1_prev     = cls_p1_ff;
         assign u_prev      = cls_u_ff;
         assign ad_prev     = cls_ad_ff;
         assign r_prev      = cls_r_ff;
         assign q_prev      = '0;
         assign status_prev = cls_status_ff;
         assign cand        = r_prev;          // integer bit, no shift
      end else begin : g_rest
         assign p1_prev     = dv_p1_ff[k-1];
         assign u_prev      = dv_u_ff[k-1];
         assign ad_prev     = dv_ad_ff[k-1];
         assign r_prev      = dv_r_ff[k-1];
         assign q_prev      = dv_q_ff[k-1];
         assign status_prev = dv_status_ff[k-1];
         assign cand        = {r_prev[RW-2:0], 1'b0};
      end

      assign ge = cand >= RW'(ad_prev);

      always_ff @(posedge clock) begin
         if (en[ST_DIV+k]) begin
            dv_p1_ff[k]     <= p1_prev;
            dv_u_ff[k]      <= u_prev;
            dv_ad_ff[k]     <= ad_prev;
            dv_r_ff[k]      <= ge ? (cand - RW'(ad_prev)) : cand;
            dv_q_ff[k]      <= {q_prev[QW-2:0], ge};
            dv_status_ff[k] <= status_prev;
         end
      end
   end

   // ---------------------------------------------------------------------
   // t * u products
   // ---------------------------------------------------------------------
   logic signed [CW-1:0] tm_p1_ff [3];
   logic signed [MW-1:0] tm_prod_ff [3];
   spi_pkg::status_type  tm_status_ff;

   always_ff @(posedge clock) begin
      if (en[ST_TMUL]) begin
         tm_p1_ff     <= dv_p1_ff[DS-1];
         tm_status_ff <= dv_status_ff[DS-1];
         for (int i = 0; i < 3; i++) begin
            tm_prod_ff[i] <= MW'($signed({1'b0, dv_q_ff[DS-1]})) * MW'(dv_u_ff[DS-1][i]);
         end
      end
   end

   // ---------------------------------------------------------------------
   // output register: p1 + floor(t*u), zero unless a point was found
   // ---------------------------------------------------------------------
   logic signed [CW-1:0] out_coord [3];
   logic signed [CW-1:0] out_xyz_ff [3];
   spi_pkg::status_type  out_status_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (tm_status_ff == spi_pkg::STATUS_POINT) begin
            out_coord[i] = tm_p1_ff[i] + CW'(tm_prod_ff[i] >>> spi_pkg::TQ_FRAC);
         end else begin
            out_coord[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_OUT]) begin
         out_xyz_ff    <= out_coord;
         out_status_ff <= tm_status_ff;
      end
   end

   assign rsp_valid      = vld_ff[NS-1];
   assign rsp_hit_status = out_status_ff;
   assign rsp_hit_x      = out_xyz_ff[0];
   assign rsp_hit_y      = out_xyz_ff[1];
   assign rsp_hit_z      = out_xyz_ff[2];

endmodule

FILE: hdl/spi_checker.sv
// port-level checker for the segment/plane intersection block, with its bind
`include "segment_plane_intersection_assert.svh"

module spi_checker #(
   parameter int COORD_WIDTH = 32
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [1:0]                    rsp_hit_status,
   input logic signed [COORD_WIDTH-1:0] rsp_hit_x,
   input logic signed [COORD_WIDTH-1:0] rsp_hit_y,
   input logic signed [COORD_WIDTH-1:0] rsp_hit_z
);

   logic not_point;
   logic known_status;

   assign not_point = rsp_hit_status != spi_pkg::STATUS_POINT;
   assign known_status = (rsp_hit_status == spi_pkg::STATUS_DISJOINT)
                      || (rsp_hit_status == spi_pkg::STATUS_POINT)
                      || (rsp_hit_status == spi_pkg::STATUS_IN_PLANE);

   // no response right after reset
   `SPI_ASSERT_IMPL(a_reset_empty, $past(reset), !rsp_valid, "response after reset")
   // status code is one of the three defined values
   `SPI_ASSERT_IMPL(a_status_code, rsp_valid, known_status, "bad status")
   // coordinates are zero unless a point was found
   `SPI_ASSERT_IMPL(a_zero_coord, rsp_valid && not_point,
      rsp_hit_x == '0 && rsp_hit_y == '0 && rsp_hit_z == '0, "nonzero miss coordinate")
   // a flowing response side never back-pressures the request side
   `SPI_ASSERT_ALWAYS(a_no_false_stall, rsp_stall || !req_stall, "stall without cause")
   // a stalled response stays valid and holds its status and x coordinate
   `SPI_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_hit_status) && $stable(rsp_hit_x), "stalled response moved")

endmodule

bind segment_plane_intersection spi_checker #(.COORD_WIDTH(COORD_WIDTH)) u_spi_checker (.*);
